[design/nfams_pkg.sv]
package nfams_pkg;

  localparam int LETTER_W = 3;
  localparam int SLOT_W   = 5;
  localparam int STATE_W  = 4;
  localparam int SET_W    = 16;
  localparam int MASK_W   = 32;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  // classified request as it sits in the queue between front and back
  typedef struct packed {
    action_t               action;
    logic                  letter_ok;
    logic                  slot_ok;
    logic [LETTER_W-1:0]   letter;
    logic [SLOT_W-1:0]     slot;
    logic [STATE_W-1:0]    source_state;
    logic [STATE_W-1:0]    target_state;
    logic [SET_W-1:0]      state_set;
    logic [MASK_W-1:0]     transition_mask;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

endpackage

[design/nfams_in_if.sv]
interface nfams_in_if;
  import nfams_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [LETTER_W-1:0] letter;
  logic [SLOT_W-1:0]   slot;
  logic [STATE_W-1:0]  source_state;
  logic [STATE_W-1:0]  target_state;
  logic [SET_W-1:0]    state_set;
  logic [MASK_W-1:0]   transition_mask;

  modport source (
    output valid, action, letter, slot, source_state, target_state, state_set,
           transition_mask,
    input  ready
  );

  modport sink (
    input  valid, action, letter, slot, source_state, target_state, state_set,
           transition_mask,
    output ready
  );

endinterface

[design/nfams_out_if.sv]
interface nfams_out_if;
  import nfams_pkg::*;

  logic             valid;
  logic             ready;
  logic [SET_W-1:0] next_set;

  modport source (
    output valid, next_set,
    input  ready
  );

  modport sink (
    input  valid, next_set,
    output ready
  );

endinterface

[design/nfa_masked_successor_set.sv]
// step request: the back end takes it from the queue, checks the mask, walks the
// letter's slots (up to 32) and drains the table read before the result is ready;
// an empty or too wide mask, or a letter out of range, skips the walk
// the back end handles one request at a time and takes the next only after the
// last is done; a step waits in its done state while a result is not yet taken
// synchronous reset clears counts, queue and output; table contents are kept
module nfa_masked_successor_set #(
  parameter int STATES  = 16,
  parameter int LETTERS = 8,
  parameter int SLOTS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  nfams_in_if.sink    req,
  nfams_out_if.source rsp
);
  import nfams_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  nfams_front #(
    .LETTERS (LETTERS),
    .SLOTS   (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  nfams_back #(
    .STATES  (STATES),
    .LETTERS (LETTERS),
    .SLOTS   (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp)
  );

endmodule

[design/nfams_front.sv]
module nfams_front #(
  parameter int LETTERS = 8,
  parameter int SLOTS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  nfams_in_if.sink          req,
  output nfams_pkg::cmd_t   cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);
  import nfams_pkg::*;

  localparam int QD = 2;

  cmd_t       q [QD];
  cmd_t       in_cmd;
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.action          = action_t'(req.action);
    in_cmd.letter_ok       = int'(req.letter) < LETTERS;
    in_cmd.slot_ok         = int'(req.slot) < SLOTS;
    in_cmd.letter          = req.letter;
    in_cmd.slot            = req.slot;
    in_cmd.source_state    = req.source_state;
    in_cmd.target_state    = req.target_state;
    in_cmd.state_set       = req.state_set;
    in_cmd.transition_mask = req.transition_mask;
  end

  assign req.ready = fill != 2'(QD);
  assign push      = req.valid && req.ready;
  assign cmd_valid = fill != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
  end

endmodule

[design/nfams_back.sv]
module nfams_back #(
  parameter int STATES  = 16,
  parameter int LETTERS = 8,
  parameter int SLOTS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  nfams_pkg::cmd_t   cmd,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  nfams_out_if.source       rsp
);
  import nfams_pkg::*;

  localparam int LW = (LETTERS > 1) ? $clog2(LETTERS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TD = LETTERS * (1 << SW);

  seq_state_t       state;
  seq_state_t       state_next;
  cmd_t             cur;

  // entry is {source, target}
  logic [2*STATE_W-1:0] tab_mem [TD];
  logic [2*STATE_W-1:0] tab_rd;
  logic [CW-1:0]        cnt_mem [LETTERS];
  logic [LETTERS-1:0]   cnt_vld;
  logic [CW-1:0]        cnt_rd;
  logic                 cnt_hit;

  logic [CW-1:0]    idx;
  logic [CW-1:0]    cnt_lim;
  logic             issued;
  logic             sel;
  logic [SET_W-1:0] acc;
  logic             out_valid;
  logic [SET_W-1:0] out_data;

  logic             tab_we;
  logic             cnt_we;
  logic             issue;
  logic             acc_clr;
  logic             out_load;

  logic [LW-1:0]    cur_l;
  logic [CW-1:0]    cnt_cur;
  logic [CW-1:0]    slot_inc;
  logic             mask_bad;
  logic [STATE_W-1:0] rd_src;
  logic [STATE_W-1:0] rd_dst;
  logic             hit;

  assign cur_l    = LW'(cur.letter);
  assign cnt_cur  = cnt_hit ? cnt_rd : '0;
  assign slot_inc = CW'(cur.slot) + CW'(1);
  // empty mask, or a bit set at or above the letter's count
  assign mask_bad = (cur.transition_mask == '0) ||
                    ((cur.transition_mask >> cnt_cur) != '0);
  assign rd_src   = tab_rd[2*STATE_W-1:STATE_W];
  assign rd_dst   = tab_rd[STATE_W-1:0];
  assign hit      = (int'(rd_src) < STATES) && cur.state_set[rd_src] &&
                    (int'(rd_dst) < STATES);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.action == ACT_LOAD) begin
            state_next = (cmd.letter_ok && cmd.slot_ok) ? ST_LOAD : ST_IDLE;
          end else begin
            state_next = cmd.letter_ok ? ST_CHECK : ST_DONE;
          end
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_CHECK: state_next = mask_bad ? ST_DONE : ST_RUN;
      ST_RUN: begin
        if (idx == cnt_lim - CW'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    tab_we    = 1'b0;
    cnt_we    = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        acc_clr   = cmd_valid;
        tab_we    = cmd_valid && (cmd.action == ACT_LOAD) && cmd.letter_ok && cmd.slot_ok;
      end
      ST_LOAD:  cnt_we   = slot_inc > cnt_cur;
      ST_CHECK: acc_clr  = 1'b1;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: issue    = 1'b0;
      ST_DONE:  out_load = !out_valid || rsp.ready;
      default:  cmd_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_vld   <= '0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issue;
      if (cnt_we) cnt_vld[cur_l] <= 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cur <= cmd;
    if (state == ST_CHECK) begin
      idx     <= '0;
      cnt_lim <= cnt_cur;
    end else if (issue) begin
      idx <= idx + CW'(1);
    end
    sel <= cur.transition_mask[SLOT_W'(idx)];
    if (acc_clr) begin
      acc <= '0;
    end else if (issued && sel && hit) begin
      acc <= acc | (SET_W'(1) << rd_dst);
    end
    if (out_load) out_data <= acc;
  end

  // transition table, one read port walked by the slot counter
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[{LW'(cmd.letter), SW'(cmd.slot)}] <= {cmd.source_state, cmd.target_state};
    tab_rd <= tab_mem[{cur_l, SW'(idx)}];
  end

  // per-letter counts, read when a request is taken and updated in the cycle after
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cur_l] <= slot_inc;
    if (cmd_ready) begin
      cnt_rd  <= cnt_mem[LW'(cmd.letter)];
      cnt_hit <= cnt_vld[LW'(cmd.letter)];
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.next_set = out_data;

endmodule

[design/nfams_chk.sv]
module nfams_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [nfams_pkg::SET_W-1:0]  rsp_next_set
);

  // a waiting result stays until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_next_set))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  // queue only fills by taking a request
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(req_valid && req_ready))
    else $error("ready dropped without a request taken");

endmodule

bind nfa_masked_successor_set nfams_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_next_set (rsp.next_set)
);

[tb/tb_nfa_masked_successor_set.sv]
module tb_nfa_masked_successor_set;
  import nfams_pkg::*;

  localparam int LETTERS      = 8;
  localparam int SLOTS        = 32;
  localparam int STATES       = 16;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 1480;
  localparam int PAUSE_AT     = 700;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 60;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    action_t             act;
    logic [LETTER_W-1:0] letter;
    logic [SLOT_W-1:0]   slot;
    logic [STATE_W-1:0]  src;
    logic [STATE_W-1:0]  dst;
    logic [SET_W-1:0]    states;
    logic [MASK_W-1:0]   mask;
  } nfa_req_t;

  typedef struct {
    nfa_req_t         req;
    bit               typed;
    logic [SET_W-1:0] want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  nfams_in_if  req_if ();
  nfams_out_if rsp_if ();

  nfa_masked_successor_set u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the transition table
  logic [STATE_W-1:0] src_tbl [LETTERS][SLOTS];
  logic [STATE_W-1:0] dst_tbl [LETTERS][SLOTS];
  int                 slot_cnt [LETTERS];
  logic [SLOTS-1:0]   loaded [LETTERS];

  logic [SET_W-1:0] next_set_q [$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               stall_left = 0;
  logic [SET_W-1:0] want_set;

  directed_row_t directed_rows [N_DIRECTED];

  initial begin
    for (int l = 0; l < LETTERS; l++) begin
      slot_cnt[l] = 0;
      loaded[l]   = '0;
    end
  end

  function automatic logic [SLOTS-1:0] below_count(int n);
    if (n >= SLOTS) return '1;
    return (SLOTS'(1) << n) - 1;
  endfunction

  function automatic logic [SET_W-1:0] successor_set(logic [LETTER_W-1:0] l,
                                                     logic [SET_W-1:0] states,
                                                     logic [MASK_W-1:0] mask);
    logic [SET_W-1:0] res;
    int               n;
    res = '0;
    if (int'(l) >= LETTERS) return '0;
    n = slot_cnt[l];
    if (mask == '0) return '0;
    // mask reaching past the letter's count gives nothing
    if (n < MASK_W && (mask & ~MASK_W'(below_count(n))) != '0) return '0;
    for (int i = 0; i < n; i++) begin
      if (mask[i] && int'(src_tbl[l][i]) < STATES && states[src_tbl[l][i]]
          && int'(dst_tbl[l][i]) < STATES)
        res[dst_tbl[l][i]] = 1'b1;
    end
    return res;
  endfunction

  task automatic record_request(nfa_req_t r, bit typed, logic [SET_W-1:0] want);
    if (r.act == ACT_LOAD) begin
      if (int'(r.letter) < LETTERS && int'(r.slot) < SLOTS) begin
        src_tbl[r.letter][r.slot] = r.src;
        dst_tbl[r.letter][r.slot] = r.dst;
        loaded[r.letter][r.slot]  = 1'b1;
        if (int'(r.slot) + 1 > slot_cnt[r.letter]) slot_cnt[r.letter] = int'(r.slot) + 1;
      end
    end else begin
      next_set_q = {next_set_q, typed ? want : successor_set(r.letter, r.states, r.mask)};
    end
  endtask

  // loads mostly in slot order; steps mostly touch loaded slots, some reach past the count
  function automatic nfa_req_t random_request();
    nfa_req_t         r;
    int               pick;
    int               n;
    int               b;
    logic [SLOTS-1:0] lo;
    r.letter = LETTER_W'($urandom_range(0, LETTERS - 1));
    r.slot   = SLOT_W'($urandom);
    r.src    = STATE_W'($urandom);
    r.dst    = STATE_W'($urandom);
    r.states = SET_W'($urandom);
    r.mask   = MASK_W'($urandom);
    n        = slot_cnt[r.letter];
    if ($urandom_range(0, 99) < 40) begin
      r.act = ACT_LOAD;
      pick  = $urandom_range(0, 9);
      if (pick < 7 && n < SLOTS) r.slot = SLOT_W'(n);
      else if (pick < 9) r.slot = SLOT_W'($urandom_range(0, (n == 0) ? 0 : n - 1));
    end else begin
      r.act = ACT_STEP;
      pick  = $urandom_range(0, 9);
      if (pick == 0) r.states = '0;
      else if (pick == 1) r.states = '1;
      lo   = below_count(n);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        r.mask = '0;
      end else if (pick <= 2 && n < SLOTS) begin
        b      = $urandom_range(n, SLOTS - 1);
        r.mask = (MASK_W'($urandom) & ~lo) | (MASK_W'(1) << b)
                 | (MASK_W'($urandom) & loaded[r.letter]);
      end else if (pick == 3) begin
        r.mask = loaded[r.letter];
      end else begin
        r.mask = MASK_W'($urandom) & loaded[r.letter];
      end
    end
    return r;
  endfunction

  task automatic drive_request(nfa_req_t r, bit typed, logic [SET_W-1:0] want);
    req_if.valid           <= 1'b1;
    req_if.action          <= r.act;
    req_if.letter          <= r.letter;
    req_if.slot            <= r.slot;
    req_if.source_state    <= r.src;
    req_if.target_state    <= r.dst;
    req_if.state_set       <= r.states;
    req_if.transition_mask <= r.mask;
    do @(posedge clk); while (!req_if.ready);
    record_request(r, typed, want);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic note_mismatch(string what, logic [SET_W-1:0] want, logic [SET_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch at %0t (%s): expected next_set %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (next_set_q.size() == 0) begin
        note_mismatch("no step request pending", '0, rsp_if.next_set);
      end else begin
        want_set = next_set_q.pop_front();
        if (rsp_if.next_set !== want_set) note_mismatch("next_set", want_set, rsp_if.next_set);
      end
    end
  end

  // receiver: runs of always ready, random, mostly stalled and fully stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= 1'($urandom_range(0, 1));
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed_rows = '{
      // empty mask, then count still zero
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'h0000_0000}, 1'b1, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'h0000_0001}, 1'b1, 16'h0000},
      '{'{ACT_STEP, 3'd7, 5'd31, 4'd15, 4'd15, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, 16'h0000},
      '{'{ACT_LOAD, 3'd0, 5'd0, 4'd0, 4'd15, 16'h0000, 32'h0000_0000}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'h0001, 32'h0000_0001}, 1'b1, 16'h8000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'hFFFE, 32'h0000_0001}, 1'b1, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'h0000_0002}, 1'b1, 16'h0000},
      '{'{ACT_LOAD, 3'd0, 5'd1, 4'd15, 4'd0, 16'h0000, 32'h0000_0000}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'h8000, 32'h0000_0003}, 1'b1, 16'h0001},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'h8001, 32'h0000_0003}, 1'b1, 16'h8001},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'h0000_0004}, 1'b1, 16'h0000},
      // top slot only, lower slots of that letter stay unloaded
      '{'{ACT_LOAD, 3'd1, 5'd31, 4'd15, 4'd15, 16'h0000, 32'h0000_0000}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd1, 5'd0, 4'd0, 4'd0, 16'h8000, 32'h8000_0000}, 1'b1, 16'h8000},
      '{'{ACT_STEP, 3'd1, 5'd0, 4'd0, 4'd0, 16'h7FFF, 32'h8000_0000}, 1'b1, 16'h0000},
      '{'{ACT_LOAD, 3'd7, 5'd0, 4'd10, 4'd5, 16'h0000, 32'h0000_0000}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd7, 5'd0, 4'd0, 4'd0, 16'h0400, 32'h0000_0001}, 1'b1, 16'h0020},
      '{'{ACT_STEP, 3'd7, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, 16'h0000},
      // overwrite keeps the count
      '{'{ACT_LOAD, 3'd0, 5'd0, 4'd3, 4'd3, 16'h0000, 32'h0000_0000}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'h8008, 32'h0000_0003}, 1'b1, 16'h0009},
      '{'{ACT_STEP, 3'd0, 5'd0, 4'd0, 4'd0, 16'h0008, 32'h0000_0002}, 1'b1, 16'h0000},
      '{'{ACT_STEP, 3'd0, 5'd31, 4'd15, 4'd15, 16'hFFFF, 32'h0000_0003}, 1'b0, 16'h0000},
      '{'{ACT_LOAD, 3'd7, 5'd1, 4'd6, 4'd6, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd7, 5'd0, 4'd0, 4'd0, 16'h0440, 32'h0000_0003}, 1'b0, 16'h0000},
      '{'{ACT_STEP, 3'd1, 5'd0, 4'd0, 4'd0, 16'hFFFF, 32'h8000_0000}, 1'b0, 16'h0000}
    };

    rst                    <= 1'b1;
    req_if.valid           <= 1'b0;
    req_if.action          <= ACT_LOAD;
    req_if.letter          <= '0;
    req_if.slot            <= '0;
    req_if.source_state    <= '0;
    req_if.target_state    <= '0;
    req_if.state_set       <= '0;
    req_if.transition_mask <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace();
      drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PAUSE_AT) begin
        // hold off until the block has answered everything
        req_if.valid <= 1'b0;
        do @(posedge clk); while (next_set_q.size() != 0);
      end else begin
        pace();
      end
      drive_request(random_request(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    do @(posedge clk); while (next_set_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && next_set_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
